### sv/wsfd_pkg.sv
// Shared types and codes for the WebSocket frame deframer.
`default_nettype none

package wsfd_pkg;

  localparam logic [3:0] OP_CONT = 4'h0;
  localparam logic [3:0] OP_TEXT = 4'h1;
  localparam logic [3:0] OP_BIN  = 4'h2;
  localparam logic [3:0] OP_PING = 4'h9;
  localparam logic [3:0] OP_PONG = 4'hA;

  localparam logic [2:0] CLS_TEXT_FIN  = 3'd0;
  localparam logic [2:0] CLS_TEXT_PART = 3'd1;
  localparam logic [2:0] CLS_BIN_FIN   = 3'd2;
  localparam logic [2:0] CLS_BIN_PART  = 3'd3;
  localparam logic [2:0] CLS_PING      = 3'd4;
  localparam logic [2:0] CLS_PONG      = 3'd5;
  localparam logic [2:0] CLS_ERROR     = 3'd6;

  localparam logic [6:0] LEN_MAX_SHORT = 7'd125;
  localparam logic [6:0] LEN_CODE_16   = 7'd126;
  localparam logic [6:0] LEN_CODE_64   = 7'd127;

  typedef struct packed {
    logic        valid;
    logic [7:0]  payload_byte;
    logic        has_byte;
    logic [2:0]  frame_class;
    logic [3:0]  header_length;
    logic [63:0] frame_length;
    logic        last_of_frame;
  } wsfd_res_t;

endpackage

`default_nettype wire

### sv/wsfd_parser.sv
// Frame header parser and payload unmasking, one byte per accepted word.
`default_nettype none

module wsfd_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               take,
  input  wire logic [7:0]         in_byte,
  input  wire logic               unmask_enable,
  output wsfd_pkg::wsfd_res_t     res
);
  import wsfd_pkg::*;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_LEN,
    PH_EXT,
    PH_KEY,
    PH_PAYLOAD
  } phase_t;

  function automatic logic [2:0] classify(input logic [7:0] b);
    logic [3:0] op;
    logic       fin;
    op  = b[3:0];
    fin = b[7];
    case (op) inside
      OP_CONT, OP_TEXT: classify = fin ? CLS_TEXT_FIN : CLS_TEXT_PART;
      OP_BIN:           classify = fin ? CLS_BIN_FIN : CLS_BIN_PART;
      OP_PING:          classify = CLS_PING;
      OP_PONG:          classify = CLS_PONG;
      default:          classify = CLS_ERROR;
    endcase
  endfunction

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [3:0]  ext_left_r, ext_left_nxt;
  logic [63:0] total_r, total_nxt;
  logic [63:0] left_r, left_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  midx_r, midx_nxt;
  logic        masked_r, masked_nxt;
  logic [2:0]  class_r, class_nxt;

  logic [7:0]  key_byte;
  logic        hdr_done;

  always_comb begin
    case (midx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    ext_left_nxt = ext_left_r;
    total_nxt    = total_r;
    left_nxt     = left_r;
    key_nxt      = key_r;
    midx_nxt     = midx_r;
    masked_nxt   = masked_r;
    class_nxt    = class_r;
    hdr_done     = 1'b0;

    res               = '0;
    res.frame_class   = class_r;
    res.frame_length  = total_r;

    case (phase_r)
      PH_LEN: begin
        masked_nxt  = in_byte[7];
        hdr_cnt_nxt = 4'd2;
        if (in_byte[6:0] <= LEN_MAX_SHORT) begin
          total_nxt = {57'd0, in_byte[6:0]};
          if (in_byte[7]) begin
            midx_nxt  = 2'd0;
            phase_nxt = PH_KEY;
          end else begin
            hdr_done = 1'b1;
          end
        end else begin
          total_nxt    = '0;
          ext_left_nxt = (in_byte[6:0] == LEN_CODE_16) ? 4'd2 : 4'd8;
          phase_nxt    = PH_EXT;
        end
      end
      PH_EXT: begin
        total_nxt    = {total_r[55:0], in_byte};
        hdr_cnt_nxt  = hdr_cnt_r + 4'd1;
        ext_left_nxt = ext_left_r - 4'd1;
        if (ext_left_r == 4'd1) begin
          if (masked_r) begin
            midx_nxt  = 2'd0;
            phase_nxt = PH_KEY;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      PH_KEY: begin
        key_nxt     = {key_r[23:0], in_byte};
        hdr_cnt_nxt = hdr_cnt_r + 4'd1;
        midx_nxt    = midx_r + 2'd1;
        if (midx_r == 2'd3) begin
          hdr_done = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        res.valid         = 1'b1;
        res.has_byte      = 1'b1;
        res.payload_byte  = (masked_r && unmask_enable) ? (in_byte ^ key_byte) : in_byte;
        res.last_of_frame = (left_r == 64'd1);
        res.header_length = hdr_cnt_r;
        left_nxt          = left_r - 64'd1;
        midx_nxt          = midx_r + 2'd1;
        if (left_r == 64'd1) begin
          phase_nxt = PH_FIRST;
        end
      end
      default: begin
        class_nxt    = classify(in_byte);
        hdr_cnt_nxt  = 4'd1;
        ext_left_nxt = '0;
        total_nxt    = '0;
        left_nxt     = '0;
        key_nxt      = '0;
        midx_nxt     = '0;
        masked_nxt   = 1'b0;
        phase_nxt    = PH_LEN;
      end
    endcase

    // The header is complete: report an empty frame or move on to the payload.
    if (hdr_done) begin
      midx_nxt = 2'd0;
      if (total_nxt == 64'd0) begin
        res.valid         = 1'b1;
        res.last_of_frame = 1'b1;
        res.header_length = hdr_cnt_nxt;
        res.frame_length  = total_nxt;
        phase_nxt         = PH_FIRST;
      end else begin
        left_nxt  = total_nxt;
        phase_nxt = PH_PAYLOAD;
      end
    end

    if (!take) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_FIRST;
      hdr_cnt_r  <= '0;
      ext_left_r <= '0;
      total_r    <= '0;
      left_r     <= '0;
      key_r      <= '0;
      midx_r     <= '0;
      masked_r   <= 1'b0;
      class_r    <= CLS_TEXT_FIN;
    end else if (take) begin
      phase_r    <= phase_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      ext_left_r <= ext_left_nxt;
      total_r    <= total_nxt;
      left_r     <= left_nxt;
      key_r      <= key_nxt;
      midx_r     <= midx_nxt;
      masked_r   <= masked_nxt;
      class_r    <= class_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/wsfd_out_reg.sv
// Result register that holds one word for the output channel.
`default_nettype none

module wsfd_out_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire wsfd_pkg::wsfd_res_t res,
  input  wire logic                out_stall,
  output logic                     busy,
  output logic                     out_valid,
  output wsfd_pkg::wsfd_res_t      data
);
  import wsfd_pkg::*;

  logic      valid_r;
  wsfd_res_t data_r;

  assign busy      = valid_r && out_stall;
  assign out_valid = valid_r;
  assign data      = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res.valid) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      data_r <= res;
    end
  end

endmodule

`default_nettype wire

### sv/websocket_frame_deframer_core.sv
// Top level of the WebSocket frame deframer.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   in_byte
//   out      output     out_valid / out_stall payload byte, flags, class, lengths
//   cfg      input      cfg_valid / cfg_ready cfg_unmask_enable
//
// A word is taken every cycle unless stalled; a payload word leaves in the next cycle.
// Header words produce no output; the last header word of an empty frame produces one.
// Reset is synchronous and returns the parser to the first header byte, unmasking on.
// Input is stalled only while the result register is full and the output is stalled.
`default_nettype none

module websocket_frame_deframer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_payload_byte,
  output logic             out_has_byte,
  output logic [2:0]       out_frame_class,
  output logic [3:0]       out_header_length,
  output logic [63:0]      out_frame_length,
  output logic             out_last_of_frame,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_unmask_enable
);
  import wsfd_pkg::*;

  logic      unmask_r;
  logic      take;
  logic      busy;
  wsfd_res_t res;
  wsfd_res_t data;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign take      = in_valid && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unmask_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unmask_r <= cfg_unmask_enable;
    end
  end

  wsfd_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .in_byte       (in_byte),
    .unmask_enable (unmask_r),
    .res           (res)
  );

  wsfd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .out_stall (out_stall),
    .busy      (busy),
    .out_valid (out_valid),
    .data      (data)
  );

  assign out_payload_byte  = data.payload_byte;
  assign out_has_byte      = data.has_byte;
  assign out_frame_class   = data.frame_class;
  assign out_header_length = data.header_length;
  assign out_frame_length  = data.frame_length;
  assign out_last_of_frame = data.last_of_frame;

`ifndef SYNTHESIS
  a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_byte) |-> (out_payload_byte == 8'd0 && out_last_of_frame))
    else $error("empty frame report is malformed");

  a_hdr_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_header_length >= 4'd2 && out_header_length <= 4'd14))
    else $error("header length out of range");

  a_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_has_byte && !out_last_of_frame) |-> (out_frame_length > 64'd1))
    else $error("non-final payload word in a frame of one byte or less");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(take) || $past(out_valid))
    else $error("input stalled with an empty result register");
`endif

endmodule

`default_nettype wire

### tb/tb_websocket_frame_deframer_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the WebSocket frame deframer core, with a frame parser predictor.
module tb_websocket_frame_deframer_core;
  import wsfd_pkg::*;

  localparam int ITEM_TARGET   = 1900;
  localparam int PHASE_WORDS   = 300;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 20;
  localparam int MAX_REPORTS   = 10;

  typedef enum logic [1:0] {FORM_SHORT, FORM_16, FORM_64} len_form_t;
  typedef enum logic [2:0] {PH_FIRST, PH_LEN, PH_EXT, PH_KEY, PH_PAYLOAD} parse_phase_t;

  class deframe_tracker_t;
    bit           unmask_on = 1'b1;
    parse_phase_t phase = PH_FIRST;
    logic [3:0]   hdr_count = '0;
    logic [3:0]   ext_left = '0;
    logic [63:0]  total_len = '0;
    logic [63:0]  bytes_left = '0;
    logic [31:0]  key = '0;
    logic [1:0]   key_pos = '0;
    bit           masked = 1'b0;
    logic [2:0]   cls = '0;
    wsfd_res_t    pending_results[$];
    int           mismatches = 0;

    function logic [2:0] class_of(logic [7:0] wd);
      case (wd[3:0])
        OP_CONT, OP_TEXT: return wd[7] ? CLS_TEXT_FIN : CLS_TEXT_PART;
        OP_BIN: return wd[7] ? CLS_BIN_FIN : CLS_BIN_PART;
        OP_PING: return CLS_PING;
        OP_PONG: return CLS_PONG;
        default: return CLS_ERROR;
      endcase
    endfunction

    function void push_result(logic [7:0] data, bit has, bit last);
      wsfd_res_t r;
      r.valid         = 1'b1;
      r.payload_byte  = data;
      r.has_byte      = has;
      r.frame_class   = cls;
      r.header_length = hdr_count;
      r.frame_length  = total_len;
      r.last_of_frame = last;
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void end_of_header();
      key_pos = '0;
      if (total_len == 0) begin
        push_result(8'h00, 1'b0, 1'b1);
        phase = PH_FIRST;
      end else begin
        bytes_left = total_len;
        phase = PH_PAYLOAD;
      end
    endfunction

    function void end_of_length();
      if (masked) begin
        key_pos = '0;
        phase = PH_KEY;
      end else begin
        end_of_header();
      end
    endfunction

    function void take_word(logic [7:0] wd);
      logic [7:0] key_byte;
      case (phase)
        PH_LEN: begin
          masked = wd[7];
          hdr_count = 4'd2;
          if (wd[6:0] <= LEN_MAX_SHORT) begin
            total_len = 64'(wd[6:0]);
            end_of_length();
          end else begin
            total_len = '0;
            ext_left = (wd[6:0] == LEN_CODE_16) ? 4'd2 : 4'd8;
            phase = PH_EXT;
          end
        end
        PH_EXT: begin
          total_len = {total_len[55:0], wd};
          hdr_count++;
          ext_left--;
          if (ext_left == 0) end_of_length();
        end
        PH_KEY: begin
          key = {key[23:0], wd};
          hdr_count++;
          key_pos++;
          if (key_pos == 0) end_of_header();
        end
        PH_PAYLOAD: begin
          key_byte = 8'(key >> (8 * (3 - int'(key_pos))));
          push_result((masked && unmask_on) ? (wd ^ key_byte) : wd, 1'b1, bytes_left == 1);
          bytes_left--;
          key_pos++;
          if (bytes_left == 0) phase = PH_FIRST;
        end
        default: begin
          cls = class_of(wd);
          hdr_count = 4'd1;
          ext_left = '0;
          total_len = '0;
          bytes_left = '0;
          key = '0;
          key_pos = '0;
          masked = 1'b0;
          phase = PH_LEN;
        end
      endcase
    endfunction

    function void match_result(wsfd_res_t got);
      wsfd_res_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result at %0t", $time);
          $display("  actual   byte=%02h has=%0d class=%0d hdr=%0d len=%016h last=%0d",
                   got.payload_byte, got.has_byte, got.frame_class, got.header_length,
                   got.frame_length, got.last_of_frame);
        end
        return;
      end
      want = pending_results.pop_front();
      if (got.payload_byte !== want.payload_byte || got.has_byte !== want.has_byte ||
          got.frame_class !== want.frame_class || got.header_length !== want.header_length ||
          got.frame_length !== want.frame_length || got.last_of_frame !== want.last_of_frame) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result mismatch at %0t", $time);
          $display("  expected byte=%02h has=%0d class=%0d hdr=%0d len=%016h last=%0d",
                   want.payload_byte, want.has_byte, want.frame_class, want.header_length,
                   want.frame_length, want.last_of_frame);
          $display("  actual   byte=%02h has=%0d class=%0d hdr=%0d len=%016h last=%0d",
                   got.payload_byte, got.has_byte, got.frame_class, got.header_length,
                   got.frame_length, got.last_of_frame);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_payload_byte;
  logic        out_has_byte;
  logic [2:0]  out_frame_class;
  logic [3:0]  out_header_length;
  logic [63:0] out_frame_length;
  logic        out_last_of_frame;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_unmask_enable = 1'b0;

  wsfd_res_t        seen_result;
  deframe_tracker_t tracker;
  int               words_sent = 0;
  int               idle_cycles = 0;
  bit               hold_off_req = 1'b0;
  bit               quiet_sender = 1'b0;

  assign seen_result = {out_valid, out_payload_byte, out_has_byte, out_frame_class,
                        out_header_length, out_frame_length, out_last_of_frame};

  websocket_frame_deframer_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_payload_byte  (out_payload_byte),
    .out_has_byte      (out_has_byte),
    .out_frame_class   (out_frame_class),
    .out_header_length (out_header_length),
    .out_frame_length  (out_frame_length),
    .out_last_of_frame (out_last_of_frame),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_unmask_enable (cfg_unmask_enable)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.match_result(seen_result);
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_word(input logic [7:0] wd);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (quiet_sender || r < 60) gap = 0;
    else if (r < 88) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= wd;
    do @(posedge clk); while (in_stall);
    tracker.take_word(wd);
    words_sent++;
  endtask

  task automatic send_frame(input logic [7:0] first, input bit masked, input len_form_t form,
                            input logic [63:0] len, input int payload_words);
    int i;
    send_word(first);
    case (form)
      FORM_SHORT: send_word({masked, len[6:0]});
      FORM_16: begin
        send_word({masked, LEN_CODE_16});
        send_word(len[15:8]);
        send_word(len[7:0]);
      end
      default: begin
        send_word({masked, LEN_CODE_64});
        for (i = 7; i >= 0; i--) send_word(len[8*i +: 8]);
      end
    endcase
    if (masked) repeat (4) send_word(8'($urandom));
    repeat (payload_words) send_word(8'($urandom));
  endtask

  task automatic send_random_frame();
    logic [7:0] first;
    bit         masked;
    int         r;
    int         n;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      first = 8'($urandom);
    end else begin
      case ($urandom_range(0, 4))
        0: first[3:0] = OP_CONT;
        1: first[3:0] = OP_TEXT;
        2: first[3:0] = OP_BIN;
        3: first[3:0] = OP_PING;
        default: first[3:0] = OP_PONG;
      endcase
      first[7] = 1'($urandom_range(0, 1));
      first[6:4] = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'b000;
    end
    masked = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 60) begin
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      send_frame(first, masked, FORM_SHORT, 64'(n), n);
    end else if (r < 72) begin
      n = ($urandom_range(0, 3) == 0) ? int'(LEN_MAX_SHORT) : $urandom_range(0, 125);
      send_frame(first, masked, FORM_SHORT, 64'(n), n);
    end else if (r < 84) begin
      n = $urandom_range(0, 20);
      send_frame(first, masked, FORM_16, 64'(n), n);
    end else if (r < 90) begin
      n = $urandom_range(126, 300);
      send_frame(first, masked, FORM_16, 64'(n), n);
    end else begin
      n = $urandom_range(0, 20);
      send_frame(first, masked, FORM_64, 64'(n), n);
    end
  endtask

  task automatic settle_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_unmask(input bit value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_unmask_enable <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.unmask_on = value;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  initial begin
    int open_len;
    int shut_len;
    int r;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_off_req) open_len = 1;
      else if ($urandom_range(0, 9) == 0) open_len = $urandom_range(50, 150);
      else open_len = $urandom_range(1, 12);
      out_stall <= 1'b0;
      repeat (open_len) @(negedge clk);
      r = $urandom_range(0, 99);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        shut_len = HOLD_CYCLES;
      end else if (r < 85) begin
        shut_len = $urandom_range(1, 3);
      end else if (r < 97) begin
        shut_len = $urandom_range(4, 15);
      end else begin
        shut_len = $urandom_range(30, 80);
      end
      out_stall <= 1'b1;
      repeat (shut_len) @(negedge clk);
    end
  end

  initial begin
    int phase_no;
    int phase_end;
    tracker = new;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Each of these frames has a different header size, from two bytes to fourteen.
    send_frame({1'b1, 3'b000, OP_TEXT}, 1'b0, FORM_SHORT, 64'd0, 0);
    send_frame({1'b1, 3'b000, OP_PING}, 1'b1, FORM_SHORT, 64'd1, 1);
    send_frame({1'b0, 3'b000, OP_BIN}, 1'b1, FORM_16, 64'd0, 0);
    send_frame({1'b1, 3'b111, OP_PONG}, 1'b0, FORM_64, 64'd2, 2);
    send_frame({1'b0, 3'b000, OP_CONT}, 1'b1, FORM_64, 64'd0, 0);

    phase_no = 0;
    while (words_sent < ITEM_TARGET) begin
      settle_idle();
      write_unmask((phase_no % 2) != 0);
      quiet_sender = (phase_no == 3);
      if (phase_no == 1) hold_off_req = 1'b1;
      phase_end = words_sent + PHASE_WORDS;
      if (phase_end > ITEM_TARGET) phase_end = ITEM_TARGET;
      while (words_sent < phase_end) send_random_frame();
      phase_no++;
    end
    quiet_sender = 1'b0;

    // A length with the top bit set can never complete, so this frame stays open to the end.
    send_frame({1'b1, 3'b000, OP_BIN}, 1'b1, FORM_64,
               64'hFFFF_FFFF_FFFF_FF00 | 64'($urandom_range(0, 255)), 24);
    settle_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
